/* hw/rtl/infix_to_postfix_converter_core_assert.svh */
// Assertion macros for the infix to postfix converter.
// ASSERT_OFF removes every check.
`ifndef INFIX_TO_POSTFIX_CONVERTER_CORE_ASSERT_SVH
`define INFIX_TO_POSTFIX_CONVERTER_CORE_ASSERT_SVH

`ifndef ASSERT_OFF

// Check an implication on every clock edge out of reset.
`define I2P_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Check that a condition in one cycle is followed by another in the next.
`define I2P_ASSERT_NEXT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) else $error(msg);

`else

`define I2P_ASSERT(lbl, prop, msg)
`define I2P_ASSERT_NEXT(lbl, pre, post, msg)

`endif

`endif

/* hw/rtl/i2p_pkg.sv */
package i2p_pkg;

  // Operator stack geometry
  localparam int STACK_DEPTH = 16;
  localparam int CNT_W       = $clog2(STACK_DEPTH + 1);
  localparam int IDX_W       = $clog2(STACK_DEPTH);

  // Operator characters (ASCII)
  localparam logic [7:0] CH_PLUS   = 8'h2B;
  localparam logic [7:0] CH_MINUS  = 8'h2D;
  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_CARET  = 8'h5E;
  localparam logic [7:0] CH_LPAREN = 8'h28;
  localparam logic [7:0] CH_RPAREN = 8'h29;

  typedef logic signed [3:0] prec_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_STEP,
    ST_FLUSH,
    ST_DRAIN
  } i2p_state_t;

  function automatic logic is_operator(input logic [7:0] c);
    return (c == CH_PLUS) || (c == CH_MINUS) || (c == CH_STAR) || (c == CH_SLASH) ||
           (c == CH_CARET) || (c == CH_LPAREN) || (c == CH_RPAREN);
  endfunction

  // Precedence of a character arriving from the input
  function automatic prec_t incoming_prec(input logic [7:0] c);
    prec_t p;
    p = prec_t'(0);
    if ((c == CH_PLUS) || (c == CH_MINUS)) p = prec_t'(1);
    else if ((c == CH_STAR) || (c == CH_SLASH)) p = prec_t'(3);
    else if (c == CH_CARET) p = prec_t'(6);
    else if (c == CH_LPAREN) p = prec_t'(7);
    return p;
  endfunction

  // Precedence of a character sitting on the stack
  function automatic prec_t stacked_prec(input logic [7:0] c);
    prec_t p;
    p = prec_t'(-1);
    if ((c == CH_PLUS) || (c == CH_MINUS)) p = prec_t'(2);
    else if ((c == CH_STAR) || (c == CH_SLASH)) p = prec_t'(4);
    else if (c == CH_CARET) p = prec_t'(5);
    else if (c == CH_LPAREN) p = prec_t'(0);
    return p;
  endfunction

endpackage

/* hw/rtl/infix_to_postfix_converter_core.sv */
// Channel  | Dir | Signals                          | Contents
// ---------+-----+----------------------------------+-----------------------------------
// s_axis   | in  | tvalid tready tdata[7:0] tlast   | symbol; tlast = last_symbol
// m_axis   | out | tvalid tready tdata[7:0] tlast   | out_symbol; tlast = end_of_run;
//          |     | tuser[0]                         | tuser = overflow
//
// Sequence: an item is taken in ST_IDLE and worked in ST_STEP; an operand or a
// push is done there. Each entry popped to the output costs one more ST_STEP pass,
// since the sequencer reads one stack top and runs one precedence compare per cycle
// while the output has room; the open parenthesis matched by a close one is dropped in the last pass.
// A last item then passes ST_FLUSH, which empties the stack, and ST_DRAIN, to close the run.
// Reset clears the sequencer, the stack count and the hold and output valid flags.
// A stalled output holds the sequencer on its next emitted beat; input waits meanwhile.
`include "infix_to_postfix_converter_core_assert.svh"

module infix_to_postfix_converter_core (
  input  logic       clk,
  input  logic       rst,
  input  logic       s_axis_tvalid,
  output logic       s_axis_tready,
  input  logic [7:0] s_axis_tdata,   // [7:0] symbol
  input  logic       s_axis_tlast,
  output logic       m_axis_tvalid,
  input  logic       m_axis_tready,
  output logic [7:0] m_axis_tdata,   // [7:0] out_symbol
  output logic       m_axis_tlast,
  output logic [0:0] m_axis_tuser    // [0] overflow
);
  import i2p_pkg::*;

  i2p_state_t state, state_next;

  logic [7:0]       sym_q;
  logic             last_q;
  logic [7:0]       stack [STACK_DEPTH];
  logic [CNT_W-1:0] count;
  logic [CNT_W-1:0] count_dec;

  logic       hold_valid;
  logic       hold_mine;
  logic [7:0] hold_sym;
  logic       hold_ovf;

  logic       out_free, emit_ok, transfer;
  logic       drain_final;
  logic       emit, emit_ovf, push, pop;
  logic [7:0] emit_sym;
  logic [7:0] top_sym;
  prec_t      top_prec, inc_prec;
  logic       full, is_op;
  i2p_state_t after_step;

  // Stack top and precedence compare inputs
  assign count_dec  = count - CNT_W'(1);
  assign top_sym    = stack[count_dec[IDX_W-1:0]];
  assign top_prec   = (count == '0) ? prec_t'(-1) : stacked_prec(top_sym);
  assign inc_prec   = incoming_prec(sym_q);
  assign is_op      = is_operator(sym_q);
  assign full       = (count == CNT_W'(STACK_DEPTH));
  assign after_step = last_q ? ST_FLUSH : ST_IDLE;

  // Hold stage feeds the output register; a beat of a final item waits in hold
  // until it is known whether another beat follows
  assign out_free    = !m_axis_tvalid || m_axis_tready;
  assign emit_ok     = !hold_valid || out_free;
  assign transfer    = hold_valid && out_free && (!hold_mine || emit || (state == ST_DRAIN));
  assign drain_final = transfer && hold_mine && (state == ST_DRAIN);

  assign s_axis_tready = (state == ST_IDLE);

  // Sequencer state
  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else     state <= state_next;
  end

  // Next state and step actions
  always_comb begin
    state_next = state;
    emit       = 1'b0;
    emit_sym   = sym_q;
    emit_ovf   = 1'b0;
    push       = 1'b0;
    pop        = 1'b0;
    unique case (state)
      ST_IDLE: begin
        if (s_axis_tvalid) state_next = ST_STEP;
      end
      ST_STEP: begin
        priority if (!is_op) begin
          if (emit_ok) begin
            emit       = 1'b1;
            state_next = after_step;
          end
        end else if (inc_prec > top_prec) begin
          priority if (sym_q == CH_RPAREN) begin
            // unmatched close parenthesis: drop
            state_next = after_step;
          end else if (!full) begin
            push       = 1'b1;
            state_next = after_step;
          end else begin
            if (emit_ok) begin
              emit       = 1'b1;
              emit_ovf   = 1'b1;
              state_next = after_step;
            end
          end
        end else if (inc_prec < top_prec) begin
          if (emit_ok) begin
            emit     = 1'b1;
            emit_sym = top_sym;
            pop      = 1'b1;
          end
        end else begin
          // matching parenthesis pair: discard both
          pop        = 1'b1;
          state_next = after_step;
        end
      end
      ST_FLUSH: begin
        priority if (count == '0) begin
          state_next = ST_DRAIN;
        end else if (top_sym == CH_LPAREN) begin
          pop = 1'b1;
        end else begin
          if (emit_ok) begin
            emit     = 1'b1;
            emit_sym = top_sym;
            pop      = 1'b1;
          end
        end
      end
      ST_DRAIN: begin
        if (!(hold_valid && hold_mine) || out_free) state_next = ST_IDLE;
      end
    endcase
  end

  // Latch the incoming beat
  always_ff @(posedge clk) begin
    if (s_axis_tvalid && s_axis_tready) begin
      sym_q  <= s_axis_tdata;
      last_q <= s_axis_tlast;
    end
  end

  // Stack count
  always_ff @(posedge clk) begin
    if (rst)       count <= '0;
    else if (push) count <= count + CNT_W'(1);
    else if (pop)  count <= count_dec;
  end

  // Stack entries
  always_ff @(posedge clk) begin
    if (push) stack[count[IDX_W-1:0]] <= sym_q;
  end

  // Hold stage
  always_ff @(posedge clk) begin
    if (rst)           hold_valid <= 1'b0;
    else if (emit)     hold_valid <= 1'b1;
    else if (transfer) hold_valid <= 1'b0;
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      hold_sym  <= emit_sym;
      hold_ovf  <= emit_ovf;
      hold_mine <= last_q;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst)                m_axis_tvalid <= 1'b0;
    else if (transfer)      m_axis_tvalid <= 1'b1;
    else if (m_axis_tready) m_axis_tvalid <= 1'b0;
  end

  always_ff @(posedge clk) begin
    if (transfer) begin
      m_axis_tdata    <= hold_sym;
      m_axis_tuser[0] <= hold_ovf;
      m_axis_tlast    <= drain_final;
    end
  end

  // Checks
  `I2P_ASSERT(a_count_range, count <= CNT_W'(STACK_DEPTH), "stack count beyond depth")
  `I2P_ASSERT(a_push_room, !(push && full), "push into a full stack")
  `I2P_ASSERT(a_idle_no_final, !(s_axis_tready && hold_valid && hold_mine), "final beat held")
  `I2P_ASSERT_NEXT(a_drain_last, drain_final, m_axis_tvalid && m_axis_tlast, "final beat lacks tlast")

endmodule
